// File: rtl/poly_fit_mse_fitness_top_defines.svh
// assertion macros used by the port-level checker file
`ifndef POLY_FIT_MSE_FITNESS_TOP_DEFINES_SVH
`define POLY_FIT_MSE_FITNESS_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define PFMF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfmf check failed");

// next-cycle implication, disabled while reset is low
`define PFMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfmf check failed");

`endif

// File: rtl/pfmf_pkg.sv
// types, constants and helpers for the polynomial fitness block
package pfmf_pkg;

    localparam int MAX_DEGREE  = 6;
    localparam int NUM_COEF    = MAX_DEGREE + 1;
    localparam int COEF_IDX_W  = $clog2(NUM_COEF);
    localparam int COUNT_WIDTH = 16;
    localparam int FRAC_BITS   = 16;
    localparam int Q_W         = 32;
    localparam int PROD_W      = 2 * Q_W;
    localparam int SUM_W       = 64;
    localparam int MEAN_W      = 46;
    localparam int FIT_W       = 32;
    localparam int POINTS_W    = 16;
    localparam int DEG_W       = 3;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 32;
    localparam int DIV_CNT_W   = $clog2(SUM_W);

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_BASE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_LAST = CFG_IDX_W'(NUM_COEF);

    localparam logic [DEG_W-1:0] DEGREE_RESET = DEG_W'(1);

    typedef logic signed [Q_W-1:0] t_q16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_DIFF,
        ST_SQ,
        ST_ACC,
        ST_FIN,
        ST_DMEAN,
        ST_DFIT_LD,
        ST_DFIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic add;
        logic diff;
        logic sq;
        logic acc;
        logic div_mean;
        logic div_fit;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic deg_zero;
        logic k_one;
        logic last;
        logic sum_zero;
        logic div_last;
        logic out_free;
    } t_dp_sts;

    function automatic t_q16 sat_from64(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = PROD_W'(signed'({1'b0, {(Q_W-1){1'b1}}}));
        lo = -hi - PROD_W'(1);
        if (v > hi) begin
            return t_q16'(hi);
        end else if (v < lo) begin
            return t_q16'(lo);
        end
        return v[Q_W-1:0];
    endfunction

    function automatic t_q16 sat_from33(input logic signed [Q_W:0] v);
        if (v[Q_W] != v[Q_W-1]) begin
            return v[Q_W] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
        end
        return v[Q_W-1:0];
    endfunction

endpackage

// File: rtl/pfmf_in_if.sv
// sample point channel
interface pfmf_in_if;
    logic                valid;
    logic                ready;
    pfmf_pkg::t_q16      sample_x;
    pfmf_pkg::t_q16      sample_y;
    logic                last_point;

    modport source (output valid, output sample_x, output sample_y, output last_point,
                    input ready);
    modport sink   (input valid, input sample_x, input sample_y, input last_point,
                    output ready);
endinterface

// File: rtl/pfmf_out_if.sv
// result channel
interface pfmf_out_if;
    logic                              valid;
    logic                              ready;
    logic [pfmf_pkg::FIT_W-1:0]        fitness_value;
    logic [pfmf_pkg::MEAN_W-1:0]       mean_error;
    logic                              perfect_fit;
    logic [pfmf_pkg::POINTS_W-1:0]     points_seen;

    modport source (output valid, output fitness_value, output mean_error,
                    output perfect_fit, output points_seen, input ready);
    modport sink   (input valid, input fitness_value, input mean_error,
                    input perfect_fit, input points_seen, output ready);
endinterface

// File: rtl/pfmf_ctrl.sv
// sequencer for evaluation, accumulation, division and result hand-off
module pfmf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pfmf_pkg::t_dp_sts   i_sts,
    output pfmf_pkg::t_dp_cmd   o_cmd
);
    import pfmf_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.deg_zero ? ST_DIFF : ST_MUL;
                end
            end
            ST_MUL:  n_state = ST_ADD;
            ST_ADD:  n_state = i_sts.k_one ? ST_DIFF : ST_MUL;
            ST_DIFF: n_state = ST_SQ;
            ST_SQ:   n_state = ST_ACC;
            ST_ACC:  n_state = i_sts.last ? ST_FIN : ST_IDLE;
            ST_FIN:  n_state = i_sts.sum_zero ? ST_OUT : ST_DMEAN;
            ST_DMEAN: begin
                if (i_sts.div_last) begin
                    n_state = ST_DFIT_LD;
                end
            end
            ST_DFIT_LD: n_state = ST_DFIT;
            ST_DFIT: begin
                if (i_sts.div_last) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_MUL:     o_cmd.mul      = 1'b1;
            ST_ADD:     o_cmd.add      = 1'b1;
            ST_DIFF:    o_cmd.diff     = 1'b1;
            ST_SQ:      o_cmd.sq       = 1'b1;
            ST_ACC:     o_cmd.acc      = 1'b1;
            ST_FIN:     o_cmd.div_mean = !i_sts.sum_zero;
            ST_DMEAN:   o_cmd.div_step = 1'b1;
            ST_DFIT_LD: o_cmd.div_fit  = 1'b1;
            ST_DFIT:    o_cmd.div_step = 1'b1;
            ST_OUT:     o_cmd.out_load = i_sts.out_free;
            default: begin
                o_cmd      = '0;
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/pfmf_dp.sv
// datapath: registers, shared multiplier, error sum and radix-2 divider
module pfmf_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pfmf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pfmf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  pfmf_pkg::t_q16                   i_sample_x,
    input  pfmf_pkg::t_q16                   i_sample_y,
    input  logic                             i_last_point,
    input  pfmf_pkg::t_dp_cmd                i_cmd,
    output pfmf_pkg::t_dp_sts                o_sts,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [pfmf_pkg::FIT_W-1:0]       o_fitness_value,
    output logic [pfmf_pkg::MEAN_W-1:0]      o_mean_error,
    output logic                             o_perfect_fit,
    output logic [pfmf_pkg::POINTS_W-1:0]    o_points_seen
);
    import pfmf_pkg::*;

    // configuration
    logic [DEG_W-1:0]      r_degree;
    t_q16                  r_coef [NUM_COEF];

    // per-point registers
    t_q16                  r_x;
    t_q16                  r_y;
    logic                  r_last;
    t_q16                  r_acc;
    logic [COEF_IDX_W-1:0] r_k;
    logic [Q_W-1:0]        r_mag;
    logic [PROD_W-1:0]     r_prod;

    // running state
    logic [SUM_W-1:0]       r_sum;
    logic [COUNT_WIDTH-1:0] r_cnt;

    // divider
    logic [SUM_W-1:0]      r_dvd;
    logic [SUM_W-1:0]      r_dvs;
    logic [SUM_W-1:0]      r_rem;
    logic [SUM_W-1:0]      r_quo;
    logic [DIV_CNT_W-1:0]  r_dcnt;
    logic [MEAN_W-1:0]     r_mean;

    // result register
    logic                  r_ov;
    logic [FIT_W-1:0]      r_fit_o;
    logic [MEAN_W-1:0]     r_mean_o;
    logic                  r_perf_o;
    logic [POINTS_W-1:0]   r_pts_o;

    logic [COEF_IDX_W-1:0]    deg_eff;
    logic [COEF_IDX_W-1:0]    coef_sel;
    t_q16                     coef_rd;
    logic signed [Q_W:0]      mul_a;
    logic signed [Q_W:0]      mul_b;
    logic signed [2*Q_W+1:0]  mul_p;
    logic signed [PROD_W-1:0] prod_shift;
    t_q16                     step_t;
    logic signed [Q_W:0]      step_sum;
    logic signed [Q_W:0]      diff;
    logic [SUM_W:0]           sum_ext;
    logic [SUM_W:0]           rem_sh;
    logic                     rem_ge;
    logic [SUM_W-1:0]         rem_nx;
    logic                     sum_zero;

    assign deg_eff  = (r_degree > DEG_W'(MAX_DEGREE)) ? COEF_IDX_W'(MAX_DEGREE)
                                                      : COEF_IDX_W'(r_degree);
    // one read port on the coefficient bank
    assign coef_sel = i_cmd.load ? deg_eff : r_k - COEF_IDX_W'(1);
    assign coef_rd  = r_coef[coef_sel];

    // shared multiplier: signed acc*x or unsigned mag*mag
    assign mul_a = i_cmd.sq ? signed'({1'b0, r_mag}) : signed'({r_acc[Q_W-1], r_acc});
    assign mul_b = i_cmd.sq ? signed'({1'b0, r_mag}) : signed'({r_x[Q_W-1], r_x});
    assign mul_p = mul_a * mul_b;

    // arithmetic shift rounds toward minus infinity
    assign prod_shift = signed'(r_prod) >>> FRAC_BITS;
    assign step_t     = sat_from64(prod_shift);
    assign step_sum   = signed'({step_t[Q_W-1], step_t}) + signed'({coef_rd[Q_W-1], coef_rd});

    assign diff    = signed'({r_acc[Q_W-1], r_acc}) - signed'({r_y[Q_W-1], r_y});
    assign sum_ext = {1'b0, r_sum} + (SUM_W+1)'(r_prod[PROD_W-1:FRAC_BITS]);

    assign rem_sh = {r_rem, r_dvd[SUM_W-1]};
    assign rem_ge = rem_sh >= {1'b0, r_dvs};
    assign rem_nx = rem_ge ? SUM_W'(rem_sh - {1'b0, r_dvs}) : rem_sh[SUM_W-1:0];

    assign sum_zero = (r_sum == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= DEGREE_RESET;
            for (int i = 0; i < NUM_COEF; i++) begin
                r_coef[i] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_DEGREE) begin
                r_degree <= i_cfg_data[DEG_W-1:0];
            end else if (i_cfg_idx >= CFG_COEF_BASE && i_cfg_idx <= CFG_COEF_LAST) begin
                r_coef[COEF_IDX_W'(i_cfg_idx - CFG_COEF_BASE)] <= t_q16'(i_cfg_data);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= i_sample_x;
            r_y    <= i_sample_y;
            r_last <= i_last_point;
            r_acc  <= coef_rd;
            r_k    <= deg_eff;
        end
        if (i_cmd.mul || i_cmd.sq) begin
            r_prod <= mul_p[PROD_W-1:0];
        end
        if (i_cmd.add) begin
            r_acc <= sat_from33(step_sum);
            r_k   <= r_k - COEF_IDX_W'(1);
        end
        if (i_cmd.diff) begin
            r_mag <= diff[Q_W] ? Q_W'(-diff) : diff[Q_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (i_cmd.out_load) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (i_cmd.acc) begin
            r_sum <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
            if (r_cnt != '1) begin
                r_cnt <= r_cnt + COUNT_WIDTH'(1);
            end
        end
    end

    // restoring divider, one quotient bit per cycle, msb first
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_mean) begin
            r_dvd  <= r_sum;
            r_dvs  <= SUM_W'(r_cnt);
            r_rem  <= '0;
            r_quo  <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div_fit) begin
            r_dvd  <= SUM_W'({r_cnt, {(2*FRAC_BITS){1'b0}}});
            r_dvs  <= r_sum;
            r_rem  <= '0;
            r_quo  <= '0;
            r_dcnt <= '0;
            r_mean <= (|r_quo[SUM_W-1:MEAN_W]) ? '1 : r_quo[MEAN_W-1:0];
        end else if (i_cmd.div_step) begin
            r_dvd  <= {r_dvd[SUM_W-2:0], 1'b0};
            r_rem  <= rem_nx;
            r_quo  <= {r_quo[SUM_W-2:0], rem_ge};
            r_dcnt <= r_dcnt + DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_perf_o <= sum_zero;
            r_pts_o  <= POINTS_W'(r_cnt);
            if (sum_zero) begin
                r_fit_o  <= '1;
                r_mean_o <= '0;
            end else begin
                r_fit_o  <= (|r_quo[SUM_W-1:FIT_W]) ? '1 : r_quo[FIT_W-1:0];
                r_mean_o <= r_mean;
            end
        end
    end

    assign o_sts.deg_zero = (deg_eff == '0);
    assign o_sts.k_one    = (r_k == COEF_IDX_W'(1));
    assign o_sts.last     = r_last;
    assign o_sts.sum_zero = sum_zero;
    assign o_sts.div_last = (r_dcnt == '1);
    assign o_sts.out_free = !r_ov || i_out_ready;

    assign o_out_valid     = r_ov;
    assign o_fitness_value = r_fit_o;
    assign o_mean_error    = r_mean_o;
    assign o_perfect_fit   = r_perf_o;
    assign o_points_seen   = r_pts_o;

endmodule

// File: rtl/poly_fit_mse_fitness_top.sv
// Polynomial fitness scorer: the user is to write the degree and coefficients (signed Q16.16)
// on the configuration port while the block is idle; the block itself does not enforce this.
// Each sample word is evaluated by Horner's rule with saturation, its squared error is added
// to a saturating 64-bit sum, and the word marked last produces one result word (fitness =
// count/sum, mean error, perfect-fit flag, point count) after which the sum and count start
// again from zero. The Horner steps and the square share a single multiplier. A last point
// also runs two 64-step bit-serial divisions (mean, then fitness); with a zero sum the
// divisions are skipped. Results sit in an output register, so the next sample is taken
// while a result still waits.
module poly_fit_mse_fitness_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pfmf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pfmf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    pfmf_in_if.sink                          i_sample,
    pfmf_out_if.source                       o_result
);
    import pfmf_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    pfmf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .o_in_ready (i_sample.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pfmf_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_sample_x      (i_sample.sample_x),
        .i_sample_y      (i_sample.sample_y),
        .i_last_point    (i_sample.last_point),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_out_valid     (o_result.valid),
        .i_out_ready     (o_result.ready),
        .o_fitness_value (o_result.fitness_value),
        .o_mean_error    (o_result.mean_error),
        .o_perfect_fit   (o_result.perfect_fit),
        .o_points_seen   (o_result.points_seen)
    );

endmodule

// File: rtl/pfmf_chk.sv
// port-level checks for the fitness scorer, bound to the top level
`include "poly_fit_mse_fitness_top_defines.svh"

module pfmf_chk (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [pfmf_pkg::FIT_W-1:0]     i_fitness_value,
    input  logic [pfmf_pkg::MEAN_W-1:0]    i_mean_error,
    input  logic                           i_perfect_fit,
    input  logic [pfmf_pkg::POINTS_W-1:0]  i_points_seen
);
    import pfmf_pkg::*;

    // a stalled word keeps its contents
    `PFMF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_fitness_value) && $stable(i_mean_error) && $stable(i_perfect_fit) && $stable(i_points_seen))

    // one point at a time: busy right after a word is taken
    `PFMF_ASSERT_NEXT(a_in_busy, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // perfect fit reports saturated fitness and zero mean
    `PFMF_ASSERT_SAME(a_perfect, i_clk, i_rst_n, i_out_valid && i_perfect_fit, (i_fitness_value == '1) && (i_mean_error == '0))

    // every result covers at least the last point
    `PFMF_ASSERT_SAME(a_points, i_clk, i_rst_n, i_out_valid, i_points_seen != '0)

    // a result never appears in the cycle right after a point is taken
    `PFMF_ASSERT_NEXT(a_no_early_out, i_clk, i_rst_n, i_in_valid && i_in_ready && !i_out_valid, !i_out_valid)

endmodule

bind poly_fit_mse_fitness_top pfmf_chk u_pfmf_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_sample.valid),
    .i_in_ready      (i_sample.ready),
    .i_out_valid     (o_result.valid),
    .i_out_ready     (o_result.ready),
    .i_fitness_value (o_result.fitness_value),
    .i_mean_error    (o_result.mean_error),
    .i_perfect_fit   (o_result.perfect_fit),
    .i_points_seen   (o_result.points_seen)
);

// File: tb/pfmf_score_checker.sv
// scoreboard that predicts the fitness result words and checks them against the block
`timescale 1ns / 100ps
module pfmf_score_checker
    import pfmf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    pfmf_in_if                    i_sample,
    pfmf_out_if                   i_result,
    output int                    o_mismatches,
    output int                    o_waiting,
    output int                    o_scores,
    output int                    o_perfect
);

    typedef struct {
        logic [FIT_W-1:0]    fitness;
        logic [MEAN_W-1:0]   mean;
        logic                perfect;
        logic [POINTS_W-1:0] points;
    } t_score;

    localparam logic [MEAN_W-1:0] MEAN_CAP = '1;

    // shadow of the block's settings and running totals
    logic [DEG_W-1:0]       degree;
    t_q16                   coef [NUM_COEF];
    logic [SUM_W-1:0]       err_sum;
    logic [COUNT_WIDTH-1:0] n_points;
    t_score                 scores_due [$];
    t_score                 due;

    function automatic t_q16 clamp_q16(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fff_ffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic t_q16 horner_q16(input t_q16 x);
        logic signed [63:0] acc;
        int                 top_k;
        int                 k;
        top_k = (int'(degree) > MAX_DEGREE) ? MAX_DEGREE : int'(degree);
        acc = coef[top_k];
        for (k = top_k - 1; k >= 0; k--) begin
            // arithmetic shift gives the floor toward minus infinity
            acc = clamp_q16((acc * x) >>> FRAC_BITS);
            acc = clamp_q16(acc + coef[k]);
        end
        return acc[31:0];
    endfunction

    task automatic absorb_point(input t_q16 x, input t_q16 y, input logic last);
        logic signed [63:0] pred;
        logic signed [63:0] meas;
        logic signed [63:0] diff;
        logic [63:0]        mag;
        logic [63:0]        sq;
        logic [63:0]        mean_full;
        logic [63:0]        quot;
        logic [64:0]        total;
        t_score             s;
        pred = horner_q16(x);
        meas = y;
        diff = pred - meas;
        mag = diff[63] ? -diff : diff;
        sq = (mag * mag) >> FRAC_BITS;
        total = {1'b0, err_sum} + {1'b0, sq};
        err_sum = total[64] ? '1 : total[63:0];
        if (n_points != '1) begin
            n_points++;
        end
        if (last) begin
            if (err_sum == '0) begin
                s.fitness = '1;
                s.mean = '0;
                s.perfect = 1'b1;
            end else begin
                mean_full = err_sum / 64'(n_points);
                s.mean = (mean_full > 64'(MEAN_CAP)) ? MEAN_CAP : mean_full[MEAN_W-1:0];
                quot = (64'(n_points) << (2 * FRAC_BITS)) / err_sum;
                s.fitness = (quot > 64'hffff_ffff) ? '1 : quot[FIT_W-1:0];
                s.perfect = 1'b0;
            end
            s.points = n_points;
            scores_due.push_back(s);
            err_sum = '0;
            n_points = '0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            degree = DEGREE_RESET;
            foreach (coef[k]) begin
                coef[k] = '0;
            end
            err_sum = '0;
            n_points = '0;
            scores_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_DEGREE) begin
                    degree = i_cfg_data[DEG_W-1:0];
                end else if (i_cfg_idx >= CFG_COEF_BASE && i_cfg_idx <= CFG_COEF_LAST) begin
                    coef[i_cfg_idx - CFG_COEF_BASE] = i_cfg_data;
                end
            end
            if (i_result.valid && i_result.ready) begin
                if (scores_due.size() == 0) begin
                    $error("result word with no score pending");
                    o_mismatches++;
                end else begin
                    due = scores_due.pop_front();
                    o_scores++;
                    if (due.perfect) begin
                        o_perfect++;
                    end
                    if (i_result.fitness_value !== due.fitness) begin
                        $error("fitness_value: expected %0h, got %0h",
                               due.fitness, i_result.fitness_value);
                        o_mismatches++;
                    end
                    if (i_result.mean_error !== due.mean) begin
                        $error("mean_error: expected %0h, got %0h",
                               due.mean, i_result.mean_error);
                        o_mismatches++;
                    end
                    if (i_result.perfect_fit !== due.perfect) begin
                        $error("perfect_fit: expected %0b, got %0b",
                               due.perfect, i_result.perfect_fit);
                        o_mismatches++;
                    end
                    if (i_result.points_seen !== due.points) begin
                        $error("points_seen: expected %0d, got %0d",
                               due.points, i_result.points_seen);
                        o_mismatches++;
                    end
                end
            end
            if (i_sample.valid && i_sample.ready) begin
                absorb_point(i_sample.sample_x, i_sample.sample_y, i_sample.last_point);
            end
        end
        o_waiting = scores_due.size();
    end

endmodule

// File: tb/tb.sv
// top of the fitness scorer testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module tb;
    import pfmf_pkg::*;

    localparam int RAND_ITEMS    = 1950;
    localparam int PHASE_ITEMS   = 160;
    localparam int HOLD_CYCLES   = 1500;
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_CYCLES  = 200;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(NUM_COEF + 1);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;

    localparam t_q16 Q_MAX = 32'sh7fff_ffff;
    localparam t_q16 Q_MIN = 32'sh8000_0000;
    localparam t_q16 Q_ONE = 32'sh0001_0000;

    typedef enum int { SET_MIXED, SET_NEAR, SET_EXACT, SET_EDGE } t_set_kind;
    typedef enum int { COEF_SMALL, COEF_FULL, COEF_EDGE, COEF_MIXED } t_coef_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    pfmf_in_if  sample_ch ();
    pfmf_out_if result_ch ();

    int   mismatches;
    int   waiting;
    int   scores;
    int   perfects;
    int   points_sent;
    int   sets_sent;
    int   rand_items;
    int   settings_used;
    logic no_gaps;
    logic hold_req;
    t_q16 coef0_now;
    t_q16 poly [NUM_COEF];

    poly_fit_mse_fitness_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_sample   (sample_ch),
        .o_result   (result_ch)
    );

    pfmf_score_checker score_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_sample     (sample_ch),
        .i_result     (result_ch),
        .o_mismatches (mismatches),
        .o_waiting    (waiting),
        .o_scores     (scores),
        .o_perfect    (perfects)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic t_q16 rand_small();
        logic [31:0] v;
        v = $urandom_range(0, 32'h0004_0000);
        return v - 32'h0002_0000;
    endfunction

    function automatic t_q16 rand_edge();
        case ($urandom_range(0, 5))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            3: return Q_ONE;
            4: return -Q_ONE;
            default: return -1;
        endcase
    endfunction

    function automatic t_q16 rand_field();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) begin
            return rand_small();
        end else if (r < 8) begin
            return t_q16'($urandom);
        end
        return rand_edge();
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // degree goes in with junk above its three bits, then the coefficients, then a spare index that must be ignored
    task automatic load_poly(input int deg);
        int k;
        write_reg(CFG_DEGREE, ($urandom << DEG_W) | CFG_DATA_W'(deg));
        for (k = 0; k < NUM_COEF; k++) begin
            write_reg(CFG_COEF_BASE + CFG_IDX_W'(k), poly[k]);
        end
        write_reg(CFG_SPARE_LO + CFG_IDX_W'($urandom_range(0, CFG_SPARE_HI - CFG_SPARE_LO)),
                  $urandom);
        coef0_now = poly[0];
        settings_used++;
    endtask

    task automatic feed_point(input t_q16 x, input t_q16 y, input logic last);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        @(negedge i_clk);
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        sample_ch.valid      <= 1'b1;
        sample_ch.sample_x   <= x;
        sample_ch.sample_y   <= y;
        sample_ch.last_point <= last;
        do begin
            @(posedge i_clk);
        end while (sample_ch.ready !== 1'b1);
        points_sent++;
    endtask

    task automatic send_set(input t_set_kind kind, input int len);
        int          i;
        t_q16        x;
        t_q16        y;
        logic [31:0] d;
        for (i = 0; i < len; i++) begin
            case (kind)
                // x of zero makes the polynomial equal to its constant term
                SET_NEAR: begin
                    d = $urandom_range(0, 510);
                    x = '0;
                    y = coef0_now + d - 32'd255;
                end
                SET_EXACT: begin
                    x = '0;
                    y = coef0_now;
                end
                SET_EDGE: begin
                    x = rand_edge();
                    y = rand_edge();
                end
                default: begin
                    x = rand_field();
                    y = rand_field();
                end
            endcase
            feed_point(x, y, i == len - 1);
        end
        sets_sent++;
    endtask

    // block idle: no word in flight and no score outstanding
    task automatic settle();
        @(negedge i_clk);
        sample_ch.valid <= 1'b0;
        wait (waiting == 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin : result_sink
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 15);
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            result_ch.ready <= 1'b1;
            do begin
                @(posedge i_clk);
            end while (result_ch.valid !== 1'b1);
        end
    end

    initial begin : stimulus
        int         phase;
        int         k;
        int         r;
        int         set_len;
        int         phase_items;
        t_set_kind  kind;
        t_coef_mode mode;
        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_idx              = '0;
        cfg_data             = '0;
        sample_ch.valid      = 1'b0;
        sample_ch.sample_x   = '0;
        sample_ch.sample_y   = '0;
        sample_ch.last_point = 1'b0;
        result_ch.ready      = 1'b0;
        no_gaps              = 1'b0;
        hold_req             = 1'b0;
        coef0_now            = '0;
        points_sent          = 0;
        sets_sent            = 0;
        rand_items           = 0;
        settings_used        = 1;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: degree one, all coefficients zero
        feed_point('0, '0, 1'b1);
        feed_point(Q_MAX, Q_MIN, 1'b1);
        sets_sent += 2;
        settle();

        // degree above the maximum, every coefficient at the top
        foreach (poly[k]) poly[k] = Q_MAX;
        load_poly(MAX_DEGREE + 1);
        feed_point(Q_MAX, Q_MIN, 1'b0);
        feed_point(Q_MIN, Q_MAX, 1'b0);
        feed_point('0, '0, 1'b1);
        sets_sent++;
        settle();

        foreach (poly[k]) poly[k] = Q_MIN;
        load_poly(MAX_DEGREE);
        feed_point(Q_MIN, Q_MIN, 1'b0);
        feed_point(Q_ONE, '0, 1'b0);
        feed_point(-1, Q_MAX, 1'b1);
        sets_sent++;
        settle();

        // constant polynomial, hit exactly by the first two points
        foreach (poly[k]) poly[k] = '0;
        poly[0] = 32'sh0001_8000;
        load_poly(0);
        feed_point(Q_MAX, poly[0], 1'b0);
        feed_point(Q_MIN, poly[0], 1'b0);
        feed_point(32'sd12345, poly[0] + 32'sd100, 1'b1);
        sets_sent++;
        settle();

        // unused high coefficients must not leak in; negative x checks floor rounding
        foreach (poly[k]) poly[k] = Q_MAX;
        poly[0] = Q_ONE;
        poly[1] = -Q_ONE;
        poly[2] = 32'sh0000_8000;
        load_poly(2);
        feed_point(-1, '0, 1'b0);
        feed_point(32'sh0003_0000, Q_ONE, 1'b0);
        feed_point(32'shfffd_0000, '0, 1'b0);
        feed_point(t_q16'($urandom), t_q16'($urandom), 1'b1);
        sets_sent++;
        settle();

        phase = 0;
        while (rand_items < RAND_ITEMS) begin
            mode = (phase < 8) ? t_coef_mode'(phase % 4) : t_coef_mode'($urandom_range(0, 3));
            for (k = 0; k < NUM_COEF; k++) begin
                case (mode)
                    COEF_SMALL: poly[k] = rand_small();
                    COEF_FULL:  poly[k] = t_q16'($urandom);
                    COEF_EDGE:  poly[k] = rand_edge();
                    default:    poly[k] = rand_field();
                endcase
            end
            load_poly((phase < 8) ? phase : $urandom_range(0, MAX_DEGREE + 1));
            no_gaps = ($urandom_range(0, 3) == 0);
            // result side holds off while short sets keep coming, so the block backs up
            if (phase == 2) begin
                no_gaps  = 1'b1;
                hold_req = 1'b1;
            end
            phase_items = 0;
            while (phase_items < PHASE_ITEMS && rand_items < RAND_ITEMS) begin
                r = $urandom_range(0, 19);
                if (r < 14) begin
                    kind = SET_MIXED;
                end else if (r < 16) begin
                    kind = SET_NEAR;
                end else if (r < 17) begin
                    kind = SET_EXACT;
                end else begin
                    kind = SET_EDGE;
                end
                r = $urandom_range(0, 9);
                if (phase == 2) begin
                    set_len = $urandom_range(1, 3);
                end else if (r < 2) begin
                    set_len = 1;
                end else if (r < 8) begin
                    set_len = $urandom_range(2, 8);
                end else begin
                    set_len = $urandom_range(9, 40);
                end
                send_set(kind, set_len);
                phase_items += set_len;
                rand_items  += set_len;
            end
            settle();
            phase++;
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("covered %0d sample words in %0d sets under %0d register settings",
                 points_sent, sets_sent, settings_used);
        $display("%0d scores compared, %0d perfect fits, one long result-side stall",
                 scores, perfects);
        if (mismatches == 0 && waiting == 0) begin
            $display("PASS poly_fit_mse_fitness_top");
        end else begin
            $display("FAIL poly_fit_mse_fitness_top");
        end
        $finish;
    end

    initial begin : watchdog
        #(30_000_000);
        $display("FAIL poly_fit_mse_fitness_top");
        $finish;
    end

endmodule
